// ===== rtl/core/vlq_varint_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// VLQ varint decoder assertion macros
// Shared assertion helpers for the decoder RTL, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VLQ_VARINT_DECODER_DEFINES_SVH
`define VLQ_VARINT_DECODER_DEFINES_SVH

// Assert that a property holds at every rising edge outside of reset.
`define VLQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Assert that a condition is never true outside of reset.
`define VLQ_ASSERT_NEVER(label, cond, msg) \
  `VLQ_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/core/vlq_pkg.sv =====
// ----------------------------------------------------------------------------
// VLQ decoder package
// Constants and word types shared by the decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package vlq_pkg;

  // Largest number of bytes in one value; the value ends after this many.
  localparam int unsigned MaxBytes = 10;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned GroupW = 7;

  // Most negative 64-bit number, given for an encoded one.
  localparam logic [ValueW-1:0] SignMin = {1'b1, {(ValueW-1){1'b0}}};

  // Input word: one encoded byte.
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
  } vlq_in_t;

  // Output word: one decoded value in both readings.
  typedef struct packed {
    logic [ValueW-1:0]        unsigned_value;
    logic signed [ValueW-1:0] signed_value;
    logic [CountW-1:0]        byte_count;
    logic                     cut_short;
  } vlq_out_t;

endpackage

// ===== rtl/core/vlq_if.sv =====
// ----------------------------------------------------------------------------
// VLQ decoder channel interfaces
// Valid/ready channels for encoded bytes and for decoded values.
// ----------------------------------------------------------------------------

// Channel that carries one encoded byte per word.
interface vlq_byte_if;
  logic            valid;
  logic            ready;
  vlq_pkg::vlq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Channel that carries one decoded value per word.
interface vlq_value_if;
  logic              valid;
  logic              ready;
  vlq_pkg::vlq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vlq_varint_decoder.sv =====
// ----------------------------------------------------------------------------
// VLQ varint decoder
// Decodes big-endian base-128 variable-length integers, one byte per word.
// ----------------------------------------------------------------------------
// The decoder takes one encoded byte per cycle on byte_i while value_o is not
// stalled, and gives one word on value_o for each finished value: the unsigned
// value, its signed reading, the number of bytes used and a flag for a value
// cut off at the ten-byte limit. Each byte is first captured in an input
// register; the accumulator shift-and-merge, the end test and the signed
// mapping then run in one pass from it into the result register, which
// drives value_o.
// The accumulator feedback keeps the rate at one byte per cycle between stalls.
// A stalled result holds both stages; the byte input keeps accepting as
// long as the input register is empty or moving on.
// ----------------------------------------------------------------------------
`include "vlq_varint_decoder_defines.svh"

module vlq_varint_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  vlq_byte_if.sink    byte_i,
  vlq_value_if.source value_o
);
  import vlq_pkg::*;

  localparam logic [CountW-1:0] LastCount = CountW'(MaxBytes);

  // Input stage.
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // Decoder state.
  logic [ValueW-1:0] acc_q, acc_d;
  logic [CountW-1:0] seen_q, seen_d;

  // Result stage.
  logic     res_valid_q, res_valid_d;
  vlq_out_t res_q, res_d;

  // Stage handshakes.
  logic advance;
  logic consume;
  logic in_take;

  // Datapath terms.
  logic [ValueW-1:0] acc_merge;
  logic [ValueW-1:0] acc_half;
  logic [CountW-1:0] count;
  logic              more;
  logic              done;
  logic [ValueW-1:0] signed_bits;

  // The result stage moves when it is empty or its word is taken.
  assign advance = !res_valid_q || value_o.ready;
  assign consume = in_valid_q && advance;
  assign byte_i.ready = !in_valid_q || advance;
  assign in_take = byte_i.valid && byte_i.ready;

  assign value_o.valid = res_valid_q;
  assign value_o.data  = res_q;

  // Shift in the next group and decide whether the value ends here.
  assign acc_merge = {acc_q[ValueW-GroupW-1:0], in_byte_q[GroupW-1:0]};
  assign acc_half  = {1'b0, acc_merge[ValueW-1:1]};
  assign count     = seen_q + CountW'(1);
  assign more      = in_byte_q[ByteW-1];
  assign done      = !more || (count >= LastCount);

  // Signed reading: even values halve, odd ones halve and negate, and an
  // encoded one gives the most negative number.
  always_comb begin
    if (!acc_merge[0]) begin
      signed_bits = acc_half;
    end else if (acc_merge == ValueW'(1)) begin
      signed_bits = SignMin;
    end else begin
      signed_bits = ValueW'(0) - acc_half;
    end
  end

  // Next state of the accumulator and the result register.
  always_comb begin
    acc_d       = acc_q;
    seen_d      = seen_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (advance) begin
      res_valid_d = 1'b0;
    end
    if (consume) begin
      if (done) begin
        acc_d                = '0;
        seen_d               = '0;
        res_valid_d          = 1'b1;
        res_d.unsigned_value = acc_merge;
        res_d.signed_value   = signed_bits;
        res_d.byte_count     = count;
        res_d.cut_short      = more;
      end else begin
        acc_d  = acc_merge;
        seen_d = count;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      acc_q       <= '0;
      seen_q      <= '0;
    end else begin
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      res_valid_q <= res_valid_d;
      acc_q       <= acc_d;
      seen_q      <= seen_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.data.in_byte;
    end
    res_q <= res_d;
  end

  // Checks on the decoder's own state.
  `VLQ_ASSERT(a_seen_below_limit, seen_q < LastCount, "byte count passed the limit")
  `VLQ_ASSERT(a_count_range,
              res_valid_q |-> (res_q.byte_count != '0 && res_q.byte_count <= LastCount),
              "result byte count out of range")
  `VLQ_ASSERT(a_cut_at_limit,
              (res_valid_q && res_q.cut_short) |-> (res_q.byte_count == LastCount),
              "cut-short result below the byte limit")
  `VLQ_ASSERT(a_stall_holds_state,
              (res_valid_q && !value_o.ready) |=> ($stable(acc_q) && $stable(seen_q)),
              "accumulator moved while the result stalled")

endmodule
